[hw/rtl/srfc_pkg.sv]
// Shared types and constants for the servo reply frame checker.
package srfc_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [2:0] FIRST_POS   = 3'd1;
  localparam logic [2:0] SUM_FIRST   = 3'd2;
  localparam logic [2:0] SUM_LAST    = 3'd6;
  localparam logic [2:0] LAST_POS    = 3'd7;

  typedef enum logic [2:0] {
    STATUS_OK,
    STATUS_CHECKSUM,
    STATUS_HEADER,
    STATUS_PRODUCT,
    STATUS_MODULE,
    STATUS_INSTRUCTION
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] expected_module;
    logic [7:0] expected_instruction;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  module_id;
    logic [7:0]  instruction_code;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [7:0]  param_third;
    logic [15:0] word_value;
  } result_t;

  typedef struct packed {
    logic go;
    logic fire;
  } core_ctrl_t;

endpackage

[hw/rtl/srfc_in_stage.sv]
// Input register stage: holds one accepted beat until the core takes it.
module srfc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  srfc_pkg::item_t item,
  input  logic          out_free,
  output logic          s1_valid,
  output logic          s1_go,
  output srfc_pkg::item_t s1_item
);
  import srfc_pkg::*;

  logic accept;

  assign s1_go      = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

endmodule

[hw/rtl/srfc_frame_core.sv]
// Frame tracker: byte position, running checksum, stored frame bytes and frame judgement.
module srfc_frame_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  srfc_pkg::item_t   s1_item,
  input  logic [7:0]        product_code,
  output srfc_pkg::core_ctrl_t ctrl,
  output srfc_pkg::result_t res
);
  import srfc_pkg::*;

  logic       frame_active;
  logic [2:0] byte_position;
  logic [7:0] running_sum;
  logic [7:0] frame_store [FIRST_POS:SUM_LAST];

  logic       is_header;
  logic       take;

  assign is_header = (s1_item.rx_byte == HEADER_BYTE);
  assign take      = go && !is_header && frame_active;
  assign ctrl.go   = go;
  assign ctrl.fire = take && (byte_position == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active  <= 1'b0;
      byte_position <= '0;
      running_sum   <= '0;
    end else if (go && is_header) begin
      frame_active  <= 1'b1;
      byte_position <= FIRST_POS;
      running_sum   <= '0;
    end else if (take) begin
      if (byte_position >= SUM_FIRST && byte_position <= SUM_LAST) begin
        running_sum <= running_sum + s1_item.rx_byte;
      end
      if (byte_position == LAST_POS) begin
        frame_active  <= 1'b0;
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = FIRST_POS; i <= SUM_LAST; i++) begin
      if (take && byte_position == 3'(i)) begin
        frame_store[i] <= s1_item.rx_byte;
      end
    end
  end

  // no frame slot holds the header byte and no branch reports STATUS_HEADER, so the header check never trips
  always_comb begin
    priority if (frame_store[1] != product_code) begin
      res.status = STATUS_PRODUCT;
    end else if (frame_store[2] != s1_item.expected_module) begin
      res.status = STATUS_MODULE;
    end else if (frame_store[3] != s1_item.expected_instruction) begin
      res.status = STATUS_INSTRUCTION;
    end else if (running_sum != s1_item.rx_byte) begin
      res.status = STATUS_CHECKSUM;
    end else begin
      res.status = STATUS_OK;
    end
    res.module_id        = frame_store[2];
    res.instruction_code = frame_store[3];
    res.param_first      = frame_store[4];
    res.param_second     = frame_store[5];
    res.param_third      = frame_store[6];
    res.word_value       = {frame_store[5], frame_store[6]};
  end

endmodule

[hw/rtl/srfc_out_stage.sv]
// Result register: holds a finished result beat until the consumer takes it.
module srfc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  srfc_pkg::core_ctrl_t ctrl,
  input  srfc_pkg::result_t res,
  output logic              out_free,
  output logic              result_valid,
  input  logic              result_stall,
  output srfc_pkg::result_t result
);
  import srfc_pkg::*;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.go && ctrl.fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.fire) begin
      result <= res;
    end
  end

endmodule

[hw/rtl/servo_reply_frame_checker.sv]
// Top level of the servo reply frame checker.
//
//   channel  direction  handshake            beat
//   item     in         item_valid/stall     rx byte, expected module, expected instruction
//   result   out        result_valid/stall   status, frame fields, word value
//   cfg      in         cfg_valid/ready      product code
//
// One byte beat per cycle when not stalled; the last byte's take loads the result register.
// Latency is set by the input register and the result register around the checker.
// Reset is synchronous; the tracker returns to hunting for a header.
// A stalled result holds the input register, which then stalls the item channel.
module servo_reply_frame_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  srfc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output srfc_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import srfc_pkg::*;

  logic       cfg_write;
  logic [7:0] product_code;
  logic       out_free;
  logic       s1_valid;
  logic       s1_go;
  item_t      s1_item;
  core_ctrl_t ctrl;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      product_code <= '0;
    end else if (cfg_write) begin
      product_code <= cfg_data;
    end
  end

  srfc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .out_free   (out_free),
    .s1_valid   (s1_valid),
    .s1_go      (s1_go),
    .s1_item    (s1_item)
  );

  srfc_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .go           (s1_go),
    .s1_item      (s1_item),
    .product_code (product_code),
    .ctrl         (ctrl),
    .res          (res)
  );

  srfc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .res          (res),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_result_from_core: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_go && ctrl.fire))
    else $error("result raised without a completed frame");

  a_no_header_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != STATUS_HEADER)
    else $error("header mismatch reported on a framed reply");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("item channel stalled without a stalled result");

  a_go_needs_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && s1_go |=> result_valid)
    else $error("completed frame did not load the result register");

endmodule
